// ===== design/rod_cutting_bottom_up_core_assert.svh =====
// ----------------------------------------------------------------------------
// Rod cutting core assertion macros
// Shared property forms for the checker, sampled on clk, off during rst.
// ----------------------------------------------------------------------------
`ifndef ROD_CUTTING_BOTTOM_UP_CORE_ASSERT_SVH
`define ROD_CUTTING_BOTTOM_UP_CORE_ASSERT_SVH

// same-cycle implication
`define RCB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RCB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rcb_pkg.sv =====
// ----------------------------------------------------------------------------
// Rod cutting package
// Field widths, item kind codes and control types shared by the core.
// ----------------------------------------------------------------------------
package rcb_pkg;

  localparam int KIND_W   = 1;
  localparam int SLOT_W   = 5;
  localparam int PRICE_W  = 16;
  localparam int ROD_W    = 6;
  localparam int PROFIT_W = 21;
  localparam int PIECE_W  = 6;

  localparam logic [KIND_W-1:0]   KIND_LOAD  = 1'b0;
  localparam logic [KIND_W-1:0]   KIND_SOLVE = 1'b1;

  localparam logic [PROFIT_W-1:0] PROFIT_MAX = 21'h1F_FFFF;

  // one add-compare term in flight towards the accumulator
  typedef struct packed {
    logic valid;
    logic first;
  } acc_ctl_t;

endpackage

// ===== design/rcb_in_if.sv =====
// ----------------------------------------------------------------------------
// Rod cutting input channel
// Valid/ready channel carrying one load or solve item per transfer.
// ----------------------------------------------------------------------------
interface rcb_in_if import rcb_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [SLOT_W-1:0]   piece_index;
  logic [PRICE_W-1:0]  price;
  logic [ROD_W-1:0]    rod_length;

  modport source (output valid, kind, piece_index, price, rod_length, input ready);
  modport sink   (input valid, kind, piece_index, price, rod_length, output ready);

endinterface

// ===== design/rcb_out_if.sv =====
// ----------------------------------------------------------------------------
// Rod cutting result channel
// Valid/ready channel carrying one cut piece per transfer.
// ----------------------------------------------------------------------------
interface rcb_out_if import rcb_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [PROFIT_W-1:0] max_profit;
  logic [PIECE_W-1:0]  piece_length;
  logic                last;

  modport source (output valid, max_profit, piece_length, last, input ready);
  modport sink   (input valid, max_profit, piece_length, last, output ready);

endinterface

// ===== design/rcb_acc.sv =====
// ----------------------------------------------------------------------------
// Rod cutting add-compare accumulator
// Adds price and sub-rod value, keeps the strictly larger sum and its cut.
// ----------------------------------------------------------------------------
module rcb_acc import rcb_pkg::*; #(
  parameter int PRICE_BITS = 16,
  parameter int SUM_W      = 22,
  parameter int CUT_W      = 6
) (
  input  logic                  clk,
  input  acc_ctl_t              ctl,
  input  logic [CUT_W-1:0]      cut,
  input  logic [PRICE_BITS-1:0] price_q,
  input  logic [SUM_W-1:0]      best_q,
  output logic [SUM_W-1:0]      q,
  output logic [CUT_W-1:0]      x
);

  logic [SUM_W-1:0] term;

  assign term = SUM_W'(price_q) + best_q;

  // first term of a row always loads; ties keep the smaller cut
  always_ff @(posedge clk) begin
    if (ctl.valid && (ctl.first || (term > q))) begin
      q <= term;
      x <= cut;
    end
  end

endmodule

// ===== design/rod_cutting_bottom_up_core.sv =====
// ----------------------------------------------------------------------------
// Rod cutting core
// Bottom-up rod cutting over price, best-value and first-cut memories.
// ----------------------------------------------------------------------------
// A load transfer writes one price. A solve of length n (saturated to
// MAX_LEN) fills best[1..n] one add-compare term per cycle while reading,
// since the price and best-value memories each have a single read port: row
// i reads its i terms, then passes through a drain and a write-back state.
// The first-cut walk then reads the first-cut memory and loads the output
// register for each piece, holding while the sink stalls. A length of zero
// gives a single empty piece. The core takes a new item once the last piece
// of a solve is in the output register, which stays until the sink takes it.
module rod_cutting_bottom_up_core import rcb_pkg::*; #(
  parameter int MAX_LEN    = 32,
  parameter int PRICE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  rcb_in_if.sink     in_ch,
  rcb_out_if.source  out_ch
);

  localparam int PA_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int BA_W  = $clog2(MAX_LEN + 1);
  localparam int SUM_W = PRICE_BITS + BA_W;
  localparam int CMP_W = (SUM_W > PROFIT_W) ? SUM_W : PROFIT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ZERO  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;
  localparam logic [2:0] S_WREAD = 3'd5;
  localparam logic [2:0] S_WEMIT = 3'd6;

  logic [2:0]            state;
  logic [BA_W-1:0]       len;
  logic [BA_W-1:0]       i_cnt;
  logic [BA_W-1:0]       j_cnt;
  logic [BA_W-1:0]       rest;
  logic [PROFIT_W-1:0]   profit;
  acc_ctl_t              pend;
  logic [BA_W-1:0]       pend_j;

  logic [PRICE_BITS-1:0] price_mem [MAX_LEN];
  logic [SUM_W-1:0]      best_mem  [MAX_LEN+1];
  logic [BA_W-1:0]       cut_mem   [MAX_LEN+1];
  logic [PRICE_BITS-1:0] price_q;
  logic [SUM_W-1:0]      best_raw;
  logic                  best_zero;
  logic [BA_W-1:0]       cut_q;

  logic                  in_fire;
  logic                  price_we;
  logic [PA_W-1:0]       price_ra;
  logic [BA_W-1:0]       best_ra;
  logic                  rd_en;
  logic [BA_W-1:0]       len_sat;
  logic [SUM_W-1:0]      best_q;
  logic [SUM_W-1:0]      acc_q;
  logic [BA_W-1:0]       acc_x;
  logic [BA_W-1:0]       cut_eff;
  logic                  out_free;
  logic                  emit;

  assign in_ch.ready = (state == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign price_we    = in_fire && (in_ch.kind == KIND_LOAD) &&
                       (32'(in_ch.piece_index) < MAX_LEN);
  assign len_sat     = (32'(in_ch.rod_length) > MAX_LEN) ? BA_W'(MAX_LEN)
                                                         : BA_W'(in_ch.rod_length);
  assign rd_en       = (state == S_READ);
  assign price_ra    = PA_W'(j_cnt - BA_W'(1));
  assign best_ra     = i_cnt - j_cnt;
  assign best_q      = best_zero ? '0 : best_raw;
  assign cut_eff     = ((cut_q == '0) || (cut_q > rest)) ? rest : cut_q;
  assign out_free    = !out_ch.valid || out_ch.ready;
  assign emit        = ((state == S_ZERO) || (state == S_WEMIT)) && out_free;

  always_ff @(posedge clk) begin
    if (price_we) begin
      price_mem[PA_W'(in_ch.piece_index)] <= PRICE_BITS'(in_ch.price);
    end
    if (rd_en) begin
      price_q <= price_mem[price_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_WRITE) begin
      best_mem[i_cnt] <= acc_q;
    end
    if (rd_en) begin
      best_raw  <= best_mem[best_ra];
      best_zero <= (best_ra == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_WRITE) begin
      cut_mem[i_cnt] <= acc_x;
    end
    if (state == S_WREAD) begin
      cut_q <= cut_mem[rest];
    end
  end

  rcb_acc #(
    .PRICE_BITS (PRICE_BITS),
    .SUM_W      (SUM_W),
    .CUT_W      (BA_W)
  ) u_acc (
    .clk     (clk),
    .ctl     (pend),
    .cut     (pend_j),
    .price_q (price_q),
    .best_q  (best_q),
    .q       (acc_q),
    .x       (acc_x)
  );

  always_ff @(posedge clk) begin
    pend_j <= j_cnt;
    if (rst) begin
      pend <= '0;
    end else begin
      pend.valid <= rd_en;
      pend.first <= (j_cnt == BA_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_ch.valid <= 1'b0;
    end else begin
      if (emit) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire && (in_ch.kind == KIND_SOLVE)) begin
            len   <= len_sat;
            i_cnt <= BA_W'(1);
            j_cnt <= BA_W'(1);
            state <= (len_sat == '0) ? S_ZERO : S_READ;
          end
        end
        S_ZERO: begin
          if (out_free) begin
            out_ch.max_profit   <= '0;
            out_ch.piece_length <= '0;
            out_ch.last         <= 1'b1;
            state               <= S_IDLE;
          end
        end
        S_READ: begin
          if (j_cnt == i_cnt) begin
            state <= S_DRAIN;
          end else begin
            j_cnt <= j_cnt + BA_W'(1);
          end
        end
        S_DRAIN: begin
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (i_cnt == len) begin
            profit <= (CMP_W'(acc_q) > CMP_W'(PROFIT_MAX)) ? PROFIT_MAX
                                                           : PROFIT_W'(acc_q);
            rest   <= len;
            state  <= S_WREAD;
          end else begin
            i_cnt <= i_cnt + BA_W'(1);
            j_cnt <= BA_W'(1);
            state <= S_READ;
          end
        end
        S_WREAD: begin
          state <= S_WEMIT;
        end
        S_WEMIT: begin
          if (out_free) begin
            out_ch.max_profit   <= profit;
            out_ch.piece_length <= PIECE_W'(cut_eff);
            out_ch.last         <= (rest == cut_eff);
            rest                <= rest - cut_eff;
            state               <= (rest == cut_eff) ? S_IDLE : S_WREAD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/rcb_checker.sv =====
// ----------------------------------------------------------------------------
// Rod cutting core checker
// Port-level properties of the core, bound to every instance.
// ----------------------------------------------------------------------------
`include "rod_cutting_bottom_up_core_assert.svh"

module rcb_checker import rcb_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic [KIND_W-1:0]   kind,
  input logic                out_valid,
  input logic                out_ready,
  input logic [PROFIT_W-1:0] max_profit,
  input logic [PIECE_W-1:0]  piece_length,
  input logic                last
);

  `RCB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(max_profit) && $stable(piece_length) && $stable(last), "result changed while stalled")
  `RCB_ASSERT_NEXT(a_solve_busy, in_valid && in_ready && (kind == KIND_SOLVE), !in_ready, "input taken during a solve")
  `RCB_ASSERT_IMP(a_walk_busy, out_valid && !last, !in_ready, "input taken before last piece")
  `RCB_ASSERT_IMP(a_piece_len, out_valid && !last, piece_length != '0, "empty piece before last")

endmodule

bind rod_cutting_bottom_up_core rcb_checker u_rcb_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .kind         (in_ch.kind),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .max_profit   (out_ch.max_profit),
  .piece_length (out_ch.piece_length),
  .last         (out_ch.last)
);

// ===== tb/rod_cutting_bottom_up_core_tb.sv =====
// ----------------------------------------------------------------------------
// Rod cutting core testbench
// Loads piece prices and solves rods of lengths up to 63, predicting the best
// profit and the cut sequence on the fly and checking each piece in order,
// with random idle cycles on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rod_cutting_bottom_up_core_tb;
  import rcb_pkg::*;

  localparam int MAX_LEN        = 32;
  localparam int PRICE_BITS     = 16;
  localparam int RANDOM_ITEMS   = 190;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 40;

  typedef struct {
    logic [PROFIT_W-1:0] profit;
    logic [PIECE_W-1:0]  piece;
    logic                last;
  } cut_piece_t;

  logic clk;
  logic rst;
  logic no_idle;
  int   fail_count;
  int   stall_cycles;

  logic [PRICE_W-1:0] price_tab [MAX_LEN];
  cut_piece_t         expected_cuts [$];

  rcb_in_if  in_ch ();
  rcb_out_if out_ch ();

  rod_cutting_bottom_up_core #(
    .MAX_LEN    (MAX_LEN),
    .PRICE_BITS (PRICE_BITS)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // sink side: ready drops with a probability of about 6 percent
  always @(posedge clk) begin
    out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 6);
  end

  // bottom-up best profit with first-cut walk; ties keep the smallest cut
  task automatic predict_cuts(input logic [ROD_W-1:0] rod);
    int         n;
    int         rest;
    int         cut;
    longint     best [0:MAX_LEN];
    int         first [0:MAX_LEN];
    longint     q;
    longint     t;
    longint     profit;
    cut_piece_t p;
    n = (rod > MAX_LEN) ? MAX_LEN : int'(rod);
    if (n == 0) begin
      p.profit = '0;
      p.piece  = '0;
      p.last   = 1'b1;
      expected_cuts.push_back(p);
      return;
    end
    best[0] = 0;
    for (int i = 1; i <= n; i++) begin
      q        = longint'(price_tab[0]) + best[i-1];
      first[i] = 1;
      for (int j = 2; j <= i; j++) begin
        t = longint'(price_tab[j-1]) + best[i-j];
        if (t > q) begin
          q        = t;
          first[i] = j;
        end
      end
      best[i] = q;
    end
    profit = (best[n] > longint'(PROFIT_MAX)) ? longint'(PROFIT_MAX) : best[n];
    rest = n;
    while (rest > 0) begin
      cut  = first[rest];
      rest = rest - cut;
      p.profit = profit[PROFIT_W-1:0];
      p.piece  = cut[PIECE_W-1:0];
      p.last   = (rest == 0);
      expected_cuts.push_back(p);
    end
  endtask

  task automatic send_item(input logic [KIND_W-1:0]  kind,
                           input logic [SLOT_W-1:0]  slot,
                           input logic [PRICE_W-1:0] price,
                           input logic [ROD_W-1:0]   rod);
    if (!no_idle && $urandom_range(0, 99) < 6) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= kind;
    in_ch.piece_index <= slot;
    in_ch.price       <= price;
    in_ch.rod_length  <= rod;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (kind == KIND_LOAD) begin
      if (slot < MAX_LEN) price_tab[slot] = price;
    end else begin
      predict_cuts(rod);
    end
  endtask

  // unused fields carry noise
  task automatic load_price(input int slot, input logic [PRICE_W-1:0] price);
    send_item(KIND_LOAD, slot[SLOT_W-1:0], price, ROD_W'($urandom_range(0, 63)));
  endtask

  task automatic solve_rod(input int len);
    send_item(KIND_SOLVE, SLOT_W'($urandom_range(0, 31)), PRICE_W'($urandom),
              len[ROD_W-1:0]);
  endtask

  task automatic test_empty_rod;
    solve_rod(0);
  endtask

  // 2+2 and a single 4 both give 10; the smaller first cut must win
  task automatic test_tie_break;
    load_price(0, 16'd1);
    load_price(1, 16'd5);
    load_price(2, 16'd8);
    load_price(3, 16'd10);
    solve_rod(4);
    solve_rod(3);
    solve_rod(1);
  endtask

  task automatic test_price_extremes;
    load_price(0, 16'hFFFF);
    load_price(1, 16'h0000);
    load_price(2, 16'h8000);
    solve_rod(3);
    load_price(0, 16'h0000);
    load_price(2, 16'h0000);
    solve_rod(3);
    solve_rod(0);
  endtask

  task automatic test_random_traffic;
    int                 tie_unit;
    int                 sel;
    int                 len;
    logic [PRICE_W-1:0] price;
    tie_unit = $urandom_range(1, 2047);
    // whole table first so that any rod length is legal from here on
    for (int s = 0; s < MAX_LEN; s++) begin
      load_price(s, (s == MAX_LEN - 1) ? 16'hFFFF : PRICE_W'($urandom));
    end
    solve_rod(63);
    solve_rod(MAX_LEN);
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      no_idle <= (k >= 70 && k < 130);
      if ($urandom_range(0, 99) < 35) begin
        sel = $urandom_range(0, 9);
        len = $urandom_range(0, MAX_LEN - 1);
        if (sel == 0)      price = '0;
        else if (sel == 1) price = '1;
        else if (sel < 4)  price = PRICE_W'((len + 1) * tie_unit);
        else               price = PRICE_W'($urandom);
        load_price(len, price);
      end else begin
        sel = $urandom_range(0, 9);
        if (sel < 6)      len = $urandom_range(0, 10);
        else if (sel < 9) len = $urandom_range(11, MAX_LEN);
        else              len = $urandom_range(MAX_LEN + 1, 63);
        solve_rod(len);
      end
    end
    no_idle <= 1'b0;
  endtask

  always @(posedge clk) begin
    cut_piece_t exp_p;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_cuts.size() == 0) begin
        $display("%0t: unexpected piece, actual profit %0d piece %0d last %0b",
                 $time, out_ch.max_profit, out_ch.piece_length, out_ch.last);
        fail_count++;
      end else begin
        exp_p = expected_cuts.pop_front();
        if (out_ch.max_profit !== exp_p.profit) begin
          $display("%0t: max_profit expected %0d actual %0d",
                   $time, exp_p.profit, out_ch.max_profit);
          fail_count++;
        end
        if (out_ch.piece_length !== exp_p.piece) begin
          $display("%0t: piece_length expected %0d actual %0d",
                   $time, exp_p.piece, out_ch.piece_length);
          fail_count++;
        end
        if (out_ch.last !== exp_p.last) begin
          $display("%0t: last expected %0b actual %0b",
                   $time, exp_p.last, out_ch.last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst               <= 1'b1;
    no_idle           <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.kind        <= KIND_LOAD;
    in_ch.piece_index <= '0;
    in_ch.price       <= '0;
    in_ch.rod_length  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_rod();
    test_tie_break();
    test_price_extremes();
    test_random_traffic();

    in_ch.valid <= 1'b0;
    while (expected_cuts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== rod_cutting_bottom_up_core.f =====
+incdir+design
design/rcb_pkg.sv
design/rcb_in_if.sv
design/rcb_out_if.sv
design/rcb_acc.sv
design/rod_cutting_bottom_up_core.sv
design/rcb_checker.sv
tb/rod_cutting_bottom_up_core_tb.sv
